@@ hdl/bjs_pkg.sv @@
// Package for the batch job scheduler: request/result payloads, sequencer
// states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bjs_pkg;

  localparam int unsigned MaxJobsDef = 64;
  localparam int unsigned SubmitW    = 24;
  localparam int unsigned RunW       = 16;
  localparam int unsigned IdxOutW    = 6;
  localparam int unsigned TimeW      = 25;
  localparam int unsigned PaddrW     = 3;

  // paddr[2] selects the register; policy sits at byte address 0
  localparam logic RegPolicy = 1'b0;

  typedef struct packed {
    logic [SubmitW-1:0] submit_time;
    logic [RunW-1:0]    run_time;
    logic               last_job;
  } job_req_t;

  typedef struct packed {
    logic [IdxOutW-1:0] job_index;
    logic [TimeW-1:0]   start_time;
    logic               last_result;
  } sched_res_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_F_RD,
    ST_F_EMIT,
    ST_A_RD,
    ST_A_CHK,
    ST_SCAN,
    ST_S_EMIT
  } state_e;

  typedef enum logic [1:0] {
    RD_FCFS,
    RD_ADMIT,
    RD_SCAN
  } rd_src_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_src_e rd_src;
    logic    admit;
    logic    scan_start;
    logic    scan_issue;
    logic    fcfs_emit;
    logic    sjf_emit;
    logic    clear;
  } bjs_cmd_t;

  typedef struct packed {
    logic last_load;
    logic out_free;
    logic admit_more;
    logic admit_ok;
    logic scan_more;
    logic final_disp;
  } bjs_sts_t;

endpackage

`default_nettype wire

@@ hdl/bjs_dp.sv @@
// Datapath of the batch job scheduler: job tables, done flags, counters,
// schedule clock, min-search registers and the result register.
// Depends on bjs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bjs_dp #(
  parameter int unsigned MAX_JOBS = bjs_pkg::MaxJobsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bjs_pkg::job_req_t  in_req_i,
  input  wire bjs_pkg::bjs_cmd_t  cmd_i,
  output bjs_pkg::bjs_sts_t       sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output bjs_pkg::sched_res_t     out_res_o
);
  import bjs_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_JOBS);
  localparam int unsigned CntW = $clog2(MAX_JOBS + 1);

  logic [SubmitW-1:0] submit_mem [MAX_JOBS];
  logic [RunW-1:0]    run_mem    [MAX_JOBS];

  logic [CntW-1:0] job_cnt_q, job_cnt_d;
  logic [CntW-1:0] admit_q, admit_d;
  logic [CntW-1:0] pend_q, pend_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [TimeW-1:0] clock_q, clock_d;
  logic             scan_vld_q;
  logic             best_any_q, best_any_d;
  logic [MAX_JOBS-1:0] done_q, done_d;
  logic             out_valid_q, out_valid_d;

  logic [SubmitW-1:0] submit_rd_q;
  logic [RunW-1:0]    run_rd_q;
  logic [IdxW-1:0]    rd_idx_q;
  logic [IdxW-1:0]    best_idx_q;
  logic [RunW-1:0]    best_run_q;
  logic [SubmitW-1:0] best_submit_q;
  sched_res_t         out_res_q;

  logic [IdxW-1:0]  wr_addr, rd_addr;
  logic [TimeW-1:0] submit_ext, start_f;
  logic             better;

  assign wr_addr    = job_cnt_q[IdxW-1:0];
  assign submit_ext = TimeW'(submit_rd_q);
  assign start_f    = (submit_ext > clock_q) ? submit_ext : clock_q;

  always_comb begin
    case (cmd_i.rd_src)
      RD_FCFS:  rd_addr = k_q[IdxW-1:0];
      RD_ADMIT: rd_addr = admit_q[IdxW-1:0];
      RD_SCAN:  rd_addr = scan_q[IdxW-1:0];
      default:  rd_addr = '0;
    endcase
  end

  // ties on run time go to the earlier submit; scan order settles index ties
  assign better = !done_q[rd_idx_q] &&
                  (!best_any_q || (run_rd_q < best_run_q) ||
                   ((run_rd_q == best_run_q) && (submit_rd_q < best_submit_q)));

  assign sts_o.last_load  = in_req_i.last_job || (job_cnt_q == CntW'(MAX_JOBS - 1));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.admit_more = admit_q < job_cnt_q;
  assign sts_o.admit_ok   = (pend_q == '0) || (submit_ext <= clock_q);
  assign sts_o.scan_more  = scan_q < admit_q;
  assign sts_o.final_disp = k_q == (job_cnt_q - CntW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      submit_mem[wr_addr] <= in_req_i.submit_time;
      run_mem[wr_addr]    <= in_req_i.run_time;
    end
    if (cmd_i.rd_en) begin
      submit_rd_q <= submit_mem[rd_addr];
      run_rd_q    <= run_mem[rd_addr];
      rd_idx_q    <= rd_addr;
    end
  end

  always_comb begin
    job_cnt_d   = job_cnt_q;
    admit_d     = admit_q;
    pend_d      = pend_q;
    k_d         = k_q;
    scan_d      = scan_q;
    clock_d     = clock_q;
    best_any_d  = best_any_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;

    if (!out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.load) job_cnt_d = job_cnt_q + CntW'(1);
    if (cmd_i.admit) begin
      admit_d = admit_q + CntW'(1);
      pend_d  = pend_q + CntW'(1);
      clock_d = start_f;
    end
    if (cmd_i.scan_start) begin
      scan_d     = '0;
      best_any_d = 1'b0;
    end
    if (cmd_i.scan_issue) scan_d = scan_q + CntW'(1);
    if (scan_vld_q && better) best_any_d = 1'b1;
    if (cmd_i.fcfs_emit) begin
      clock_d     = start_f + TimeW'(run_rd_q);
      k_d         = k_q + CntW'(1);
      out_valid_d = 1'b1;
    end
    if (cmd_i.sjf_emit) begin
      clock_d            = clock_q + TimeW'(best_run_q);
      k_d                = k_q + CntW'(1);
      pend_d             = pend_q - CntW'(1);
      done_d[best_idx_q] = 1'b1;
      out_valid_d        = 1'b1;
    end
    if (cmd_i.clear) begin
      job_cnt_d = '0;
      admit_d   = '0;
      pend_d    = '0;
      k_d       = '0;
      clock_d   = '0;
      done_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_cnt_q   <= '0;
      admit_q     <= '0;
      pend_q      <= '0;
      k_q         <= '0;
      scan_q      <= '0;
      clock_q     <= '0;
      scan_vld_q  <= 1'b0;
      best_any_q  <= 1'b0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_cnt_q   <= job_cnt_d;
      admit_q     <= admit_d;
      pend_q      <= pend_d;
      k_q         <= k_d;
      scan_q      <= scan_d;
      clock_q     <= clock_d;
      scan_vld_q  <= cmd_i.scan_issue;
      best_any_q  <= best_any_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_vld_q && better) begin
      best_idx_q    <= rd_idx_q;
      best_run_q    <= run_rd_q;
      best_submit_q <= submit_rd_q;
    end
    if (cmd_i.fcfs_emit) begin
      out_res_q.job_index   <= IdxOutW'(k_q);
      out_res_q.start_time  <= start_f;
      out_res_q.last_result <= sts_o.final_disp;
    end else if (cmd_i.sjf_emit) begin
      out_res_q.job_index   <= IdxOutW'(best_idx_q);
      out_res_q.start_time  <= clock_q;
      out_res_q.last_result <= sts_o.final_disp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTH
  a_pend_le_admit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= admit_q) else $error("pending count exceeds admitted count");

  a_admit_le_jobs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    admit_q <= job_cnt_q) else $error("admit pointer past loaded jobs");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fcfs_emit || cmd_i.sjf_emit) |-> sts_o.out_free)
    else $error("dispatch while result register is held");

  a_sjf_pick_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sjf_emit |-> (best_any_q && !done_q[best_idx_q] && (pend_q != '0)))
    else $error("dispatch without a pending pick");
`endif

endmodule

`default_nettype wire

@@ hdl/bjs_ctrl.sv @@
// Sequencer of the batch job scheduler: load phase, FCFS walk and SJF
// admit / scan / dispatch loop. Drives bjs_dp by command bundle. Depends on bjs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bjs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              policy_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire bjs_pkg::bjs_sts_t sts_i,
  output bjs_pkg::bjs_cmd_t      cmd_o
);
  import bjs_pkg::*;

  state_e state_q, state_d;
  logic   pol_q, pol_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pol_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      pol_q   <= pol_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pol_d      = pol_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.rd_src = RD_FCFS;

    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.last_load) begin
            pol_d   = policy_i;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        state_d = pol_q ? ST_A_RD : ST_F_RD;
      end
      ST_F_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_FCFS;
        state_d      = ST_F_EMIT;
      end
      ST_F_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.fcfs_emit = 1'b1;
          if (sts_i.final_disp) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            state_d = ST_F_RD;
          end
        end
      end
      ST_A_RD: begin
        if (sts_i.admit_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_ADMIT;
          state_d      = ST_A_CHK;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      // empty pool admits the next job regardless and jumps the clock
      ST_A_CHK: begin
        if (sts_i.admit_ok) begin
          cmd_o.admit = 1'b1;
          state_d     = ST_A_RD;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_more) begin
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_src     = RD_SCAN;
          cmd_o.scan_issue = 1'b1;
        end else begin
          state_d = ST_S_EMIT;
        end
      end
      ST_S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.sjf_emit = 1'b1;
          if (sts_i.final_disp) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            state_d = ST_A_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

`ifndef SYNTH
  a_stall_outside_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> in_stall_o) else $error("request taken while scheduling");

  a_clear_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> (sts_i.final_disp && (cmd_o.fcfs_emit || cmd_o.sjf_emit)))
    else $error("batch cleared before final dispatch");

  a_start_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START) |-> $past(cmd_o.load)) else $error("schedule without last load");
`endif

endmodule

`default_nettype wire

@@ hdl/batch_job_scheduler_sjf_fcfs_unit.sv @@
// Channel | dir | handshake              | payload
// in      | in  | in_valid_i / in_stall_o | in_req_i  (bjs_pkg::job_req_t)
// out     | out | out_valid_o / out_stall_i | out_res_o (bjs_pkg::sched_res_t)
// cfg     | in  | APB psel/penable/pready | policy at byte address 0
// Loading accepts requests until the last job or a full table. FCFS then reads and
// emits each job in turn (F_RD, F_EMIT). SJF reads and checks each admitted job
// (A_RD, A_CHK), then scans the job table read port one entry per cycle and emits
// the shortest pending job (S_EMIT). Input stalls during scheduling.
// Reset is asynchronous, active low; policy resets to shortest job first.
// Output stall holds the result register and pauses the dispatch sequence.
`timescale 1ns / 1ps
`default_nettype none

module batch_job_scheduler_sjf_fcfs_unit #(
  parameter int unsigned MAX_JOBS = bjs_pkg::MaxJobsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire bjs_pkg::job_req_t            in_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output bjs_pkg::sched_res_t               out_res_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bjs_pkg::PaddrW-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bjs_pkg::*;

  logic     policy_q, policy_d;
  bjs_cmd_t cmd;
  bjs_sts_t sts;

  assign pready = 1'b1;

  always_comb begin
    policy_d = policy_q;
    if (psel && penable && pwrite && pready && (paddr[2] == RegPolicy)) begin
      policy_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b1;
    end else begin
      policy_q <= policy_d;
    end
  end

  assign prdata = (paddr[2] == RegPolicy) ? {31'b0, policy_q} : 32'b0;

  bjs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .policy_i   (policy_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bjs_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire
